// ===== rtl/pssim_pkg.sv =====
package pssim_pkg;

  localparam int unsigned MaxPatchPixelsDef = 4096;
  localparam int unsigned AccW = 28;
  localparam logic [31:0] StabConstReset = 32'd425984;

  // Widths of the shared divider.
  localparam int unsigned DivNW = 64;
  localparam int unsigned DivDW = 34;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StMul   = 11'b00000000010,
    StDivS  = 11'b00000000100,
    StWaitS = 11'b00000001000,
    StGcur  = 11'b00000010000,
    StWaitG = 11'b00000100000,
    StDivQ  = 11'b00001000000,
    StWaitQ = 11'b00010000000,
    StDivR  = 11'b00100000000,
    StWaitR = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  typedef enum logic [1:0] {
    DivSel = 2'd0,
    DivGcur = 2'd1,
    DivQ1 = 2'd2,
    DivGref = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_take;
    logic     finish;
  } pssim_cmd_t;

  typedef struct packed {
    logic div_done;
  } pssim_sts_t;

endpackage

// ===== rtl/pssim_in_if.sv =====
interface pssim_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ref_pixel;
  logic [15:0] cur_pixel;
  logic        last_in;
  modport source (output valid, ref_pixel, cur_pixel, last_in, input ready);
  modport sink (input valid, ref_pixel, cur_pixel, last_in, output ready);
endinterface

// ===== rtl/pssim_out_if.sv =====
interface pssim_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] similarity;
  logic [31:0] grad_current;
  logic [31:0] grad_reference;
  logic [27:0] running_total;
  logic        last_out;
  modport source (output valid, similarity, grad_current, grad_reference,
                  running_total, last_out, input ready);
  modport sink (input valid, similarity, grad_current, grad_reference,
                running_total, last_out, output ready);
endinterface

// ===== rtl/pssim_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pssim_div import pssim_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [DivNW-1:0] quo_o,
  output logic [DivDW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(DivNW + 1);

  logic [DivNW-1:0] quo_q, quo_d;
  logic [DivDW-1:0] rem_q, rem_d;
  logic [DivDW-1:0] den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivDW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivNW-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivDW]) begin
        rem_d = trial[DivDW-1:0];
        quo_d = {quo_q[DivNW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivDW-2:0], quo_q[DivNW-1]};
        quo_d = {quo_q[DivNW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/pssim_ctrl.sv =====
// Sequencer for one pixel: products, then four divisions in turn unless the denominator is zero.
module pssim_ctrl import pssim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       den_zero_i,
  input  pssim_sts_t sts_i,
  output pssim_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DivSel;
    // The output register may still hold the previous result.
    in_ready_o = (state_q == StIdle) && !(out_valid_i && !out_ready_i);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StDivS;
      end
      StDivS: begin
        if (den_zero_i) begin
          state_d = StOut;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = StWaitS;
        end
      end
      StWaitS: begin
        cmd_o.div_sel = DivSel;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = StGcur;
        end
      end
      StGcur: begin
        cmd_o.div_sel = DivGcur;
        cmd_o.div_start = 1'b1;
        state_d = StWaitG;
      end
      StWaitG: begin
        cmd_o.div_sel = DivGcur;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = StDivQ;
        end
      end
      StDivQ: begin
        cmd_o.div_sel = DivQ1;
        cmd_o.div_start = 1'b1;
        state_d = StWaitQ;
      end
      StWaitQ: begin
        cmd_o.div_sel = DivQ1;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = StDivR;
        end
      end
      StDivR: begin
        cmd_o.div_sel = DivGref;
        cmd_o.div_start = 1'b1;
        state_d = StWaitR;
      end
      StWaitR: begin
        cmd_o.div_sel = DivGref;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_i || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== rtl/pssim_dp.sv =====
// Datapath: operand registers, products, the shared divider and the
// result register with the patch accumulator.
module pssim_dp import pssim_pkg::*; #(
  parameter int unsigned MaxPatchPixels = MaxPatchPixelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] stab_const_i,
  input  logic [15:0] ref_pixel_i,
  input  logic [15:0] cur_pixel_i,
  input  logic        last_in_i,
  input  pssim_cmd_t  cmd_i,
  output pssim_sts_t  sts_o,
  output logic        den_zero_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [15:0] similarity_o,
  output logic [31:0] grad_current_o,
  output logic [31:0] grad_reference_o,
  output logic [AccW-1:0] running_total_o,
  output logic        last_out_o
);
  localparam logic [63:0] CapRaw = 64'(MaxPatchPixels) * 64'd32768;
  localparam logic [AccW-1:0] AccCap =
    (CapRaw < 64'((1 << AccW) - 1)) ? CapRaw[AccW-1:0] : {AccW{1'b1}};

  logic [15:0] r_q, t_q;
  logic        last_q;
  logic [31:0] c_q;
  logic [33:0] den_q;
  logic [33:0] num_q;
  logic [31:0] rr_q, tt_q, rt_q;
  logic [15:0] s_q;
  logic        dneg_q;
  logic        nneg_q;
  logic [50:0] nmag_q;
  logic [31:0] gcur_q, gref_q;
  logic [50:0] q1_q;
  logic        q1_big_q;

  // Partial products of the gradient numerator, formed combinationally
  // from the operand registers.
  logic [15:0] st_x;
  logic [31:0] st_p;
  logic signed [33:0] tt_rr;
  logic signed [50:0] a_p;
  logic signed [18:0] t2r;
  logic signed [51:0] b_p;
  logic signed [52:0] n_sum;

  logic [63:0] dv_num;
  logic        dv_done;
  logic [63:0] dv_quo;
  logic [33:0] dv_rem;
  logic [63:0] rnd_q;
  logic        rnd_up;
  logic        ovf;
  logic        ovf_big;
  logic        ovf_neg;

  logic        out_valid_q;
  logic [AccW-1:0] acc_q;
  logic [AccW:0]   acc_sum;
  logic [AccW-1:0] acc_new;

  assign st_x  = s_q;
  assign st_p  = st_x * t_q;
  assign tt_rr = $signed({2'b0, tt_q}) - $signed({2'b0, rr_q});
  assign a_p   = 51'($signed({1'b0, t_q}) * tt_rr);
  assign t2r   = $signed({3'b0, t_q}) - $signed({2'b0, r_q, 1'b0});
  assign b_p   = $signed({1'b0, c_q}) * t2r;
  assign n_sum = $signed({{2{a_p[50]}}, a_p}) + $signed({b_p[51], b_p});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q    <= ref_pixel_i;
      t_q    <= cur_pixel_i;
      last_q <= last_in_i;
      c_q    <= stab_const_i;
      rr_q   <= ref_pixel_i * ref_pixel_i;
      tt_q   <= cur_pixel_i * cur_pixel_i;
      rt_q   <= ref_pixel_i * cur_pixel_i;
      gcur_q <= '0;
      gref_q <= '0;
      s_q    <= 16'd32768;
    end
    if (cmd_i.mul) begin
      den_q  <= 34'(rr_q) + 34'(tt_q) + 34'(c_q);
      num_q  <= {1'b0, rt_q, 1'b0} + 34'(c_q);
      nneg_q <= n_sum[52];
      nmag_q <= n_sum[52] ? 51'(-n_sum) : 51'(n_sum);
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DivSel: s_q <= rnd_q[15:0];
        DivGcur: gcur_q <= ovf ? (dneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF)
                        : (dneg_q ? 32'(-rnd_q[31:0]) : rnd_q[31:0]);
        DivQ1: begin
          q1_q     <= dv_quo[50:0];
          q1_big_q <= |dv_quo[63:50];
        end
        default: gref_q <= (q1_big_q || ovf)
                         ? (nneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF)
                         : (nneg_q ? 32'(-rnd_q[31:0]) : rnd_q[31:0]);
      endcase
    end
    // d = r * 2^15 - s * t, ready once s is known.
    if (cmd_i.div_take && cmd_i.div_sel == DivSel) begin
      dneg_q <= 1'b0;
    end
    if (cmd_i.div_start && cmd_i.div_sel == DivGcur) begin
      dneg_q <= st_p > {1'b0, r_q, 15'd0};
    end
  end

  // The gradient magnitude is formed in the start cycle from the current
  // registers, so it is computed combinationally for the divider input.
  logic [31:0] dmag_now;
  assign dmag_now = (st_p > {1'b0, r_q, 15'd0}) ? st_p - {1'b0, r_q, 15'd0}
                                                 : {1'b0, r_q, 15'd0} - st_p;

  // The stored magnitude is |a + b|; the numerator is twice that, so it
  // is shifted by one more place than the 2^12 scaling.
  always_comb begin
    case (cmd_i.div_sel)
      DivSel:  dv_num = {15'd0, num_q, 15'd0};
      DivGcur: dv_num = {22'd0, dmag_now, 10'd0};
      DivQ1:   dv_num = {nmag_q, 13'd0};
      default: dv_num = {1'b0, q1_q, 12'd0};
    endcase
  end

  pssim_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (dv_num),
    .den_i  (den_q),
    .done_o (dv_done),
    .quo_o  (dv_quo),
    .rem_o  (dv_rem)
  );

  // Round to nearest with ties away: up when 2*rem >= den.
  assign rnd_up = {1'b0, dv_rem, 1'b0} >= {2'b0, den_q};
  assign rnd_q  = dv_quo + 64'(rnd_up);

  // A negative result may reach -2^31, a positive one only 2^31 - 1.
  assign ovf_big = |rnd_q[63:32];
  assign ovf_neg = (cmd_i.div_sel == DivGcur) ? dneg_q : nneg_q;
  assign ovf     = ovf_big || (ovf_neg ? rnd_q[31:0] > 32'h8000_0000 : rnd_q[31]);

  assign sts_o.div_done = dv_done;
  assign den_zero_o     = (den_q == '0);

  assign acc_sum = {1'b0, acc_q} + (AccW + 1)'(s_q);
  assign acc_new = (acc_sum > {1'b0, AccCap}) ? AccCap : acc_sum[AccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        acc_q       <= last_q ? '0 : acc_new;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      similarity_o     <= s_q;
      grad_current_o   <= gcur_q;
      grad_reference_o <= gref_q;
      running_total_o  <= acc_new;
      last_out_o       <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== rtl/pixelwise_ssim_with_gradients_core.sv =====
// Pixelwise structural similarity with gradients. Each input transaction
// carries a template pixel and a current pixel (unsigned Q8.8) and yields
// one output transaction: the similarity (unsigned Q1.15), its gradients with
// respect to the current and template pixels (saturated signed Q15.16),
// and a running patch sum that clears after the transaction marked last.
// A pixel passes through the squares, the products and four divisions in
// turn on a single shared restoring divider, each with its start and
// hand-off, then the output and idle states; a new pixel is taken only in
// the idle state. A zero denominator skips the divisions. The input also
// waits while the output register holds a result that has not been taken.
// The user writes the constant c through stab_we_i/stab_data_i only while
// the block is idle; the block itself does not enforce this.
module pixelwise_ssim_with_gradients_core import pssim_pkg::*; #(
  parameter int unsigned MaxPatchPixels = MaxPatchPixelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        stab_we_i,
  input  logic [31:0] stab_data_i,
  pssim_in_if.sink    in_if,
  pssim_out_if.source out_if
);
  logic [31:0] stab_q;
  pssim_cmd_t  cmd;
  pssim_sts_t  sts;
  logic        den_zero;
  logic        out_valid;

  // Configuration register for the stabilizing constant.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stab_q <= StabConstReset;
    end else if (stab_we_i) begin
      stab_q <= stab_data_i;
    end
  end

  // The controller sequences one pixel through the datapath.
  pssim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_i(out_valid),
    .out_ready_i(out_if.ready),
    .den_zero_i (den_zero),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pssim_dp #(.MaxPatchPixels(MaxPatchPixels)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stab_const_i    (stab_q),
    .ref_pixel_i     (in_if.ref_pixel),
    .cur_pixel_i     (in_if.cur_pixel),
    .last_in_i       (in_if.last_in),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .den_zero_o      (den_zero),
    .out_ready_i     (out_if.ready),
    .out_valid_o     (out_valid),
    .similarity_o    (out_if.similarity),
    .grad_current_o  (out_if.grad_current),
    .grad_reference_o(out_if.grad_reference),
    .running_total_o (out_if.running_total),
    .last_out_o      (out_if.last_out)
  );

  assign out_if.valid = out_valid;
endmodule
